[rtl/sssd_pkg.sv]
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared constants, glyph tables and helper functions for the seven-segment
// serial driver.
// ----------------------------------------------------------------------------
`default_nettype none

package sssd_pkg;

    localparam int NUM_DIGITS   = 4;
    localparam int BYTE_BITS    = 8;
    localparam int FRAME_BITS   = 2 * BYTE_BITS;
    localparam int BIT_CNT_W    = $clog2(FRAME_BITS);
    localparam int POS_W        = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    localparam int NUMBER_W     = 14;
    localparam int CHAR_W       = 8;
    localparam int POSITION_W   = 2;
    localparam int DIGIT_W      = 4;

    localparam logic [NUMBER_W-1:0] NUMBER_LIMIT = 14'd9999;
    localparam logic [7:0]          BLANK_GLYPH  = 8'hFF;

    // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every 14-bit v
    localparam int                  RECIP_SHIFT  = 16;
    localparam logic [12:0]         RECIP_10     = 13'd6554;
    localparam int                  PROD_W       = NUMBER_W + 13;
    localparam int                  QUOT_W       = PROD_W - RECIP_SHIFT;

    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_Z = 8'h7A;
    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_Z = 8'h5A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CASE_FOLD = 8'h20;

    localparam logic [7:0] LETTER_GLYPH [26] = '{
        8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hC2, 8'h89, 8'hCF,
        8'hE1, 8'h8A, 8'hC7, 8'hEA, 8'hC8, 8'hC0, 8'h8C, 8'h4A, 8'hCC,
        8'h92, 8'h87, 8'hC1, 8'hC1, 8'hD5, 8'h89, 8'h91, 8'hA4
    };

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_LOAD  = 4'b0100,
        ST_SHIFT = 4'b1000
    } state_t;

    function automatic logic [7:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [7:0] g;
        case (d)
            4'd0:    g = 8'hC0;
            4'd1:    g = 8'hF9;
            4'd2:    g = 8'hA4;
            4'd3:    g = 8'hB0;
            4'd4:    g = 8'h99;
            4'd5:    g = 8'h92;
            4'd6:    g = 8'h82;
            4'd7:    g = 8'hF8;
            4'd8:    g = 8'h80;
            4'd9:    g = 8'h90;
            default: g = BLANK_GLYPH;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] char_glyph(input logic [CHAR_W-1:0] c);
        logic [7:0] u;
        logic [7:0] g;
        logic [7:0] ofs;
        u = c;
        if (c >= CHAR_LC_A && c <= CHAR_LC_Z)
        begin
            u = c - CASE_FOLD;
        end
        g = BLANK_GLYPH;
        if (u >= CHAR_ZERO && u <= CHAR_NINE)
        begin
            ofs = u - CHAR_ZERO;
            g   = digit_glyph(ofs[DIGIT_W-1:0]);
        end
        else if (u >= CHAR_UC_A && u <= CHAR_UC_Z)
        begin
            ofs = u - CHAR_UC_A;
            g   = LETTER_GLYPH[ofs[4:0]];
        end
        return g;
    endfunction

    // Digit select byte: unused high bits set, only the selected bit set among the low bits.
    function automatic logic [7:0] select_byte(input logic [2:0] pos);
        logic [15:0] v;
        v = (16'h00FF << NUM_DIGITS) | (16'h0001 << pos);
        return v[7:0];
    endfunction

endpackage

`default_nettype wire

[rtl/seven_segment_serial_driver_unit.sv]
// ----------------------------------------------------------------------------
// seven_segment_serial_driver_unit
// Turns show-number and show-character requests into 16-bit serial frames for
// two chained 8-bit shift registers driving a multiplexed seven-segment display.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) takes one request: s_tuser selects show-number (0) or
//   show-character (1); s_tdata carries number, character and position.
//   Master channel (m_*) gives one shift-clock pulse per bit: m_tdata[0]
//   is the serial data level, m_tuser flags the sixteenth bit of a frame (the
//   latch line drops after it), m_tlast flags the final bit of the request.
//   Each frame is the segment byte MSB first, then the digit-select byte.
// Sequence per request (a stall on the master side holds a frame bit):
//   show-number : accept, then the shared divide-by-10 unit yields the digits
//                 rightmost first, then per digit a load and the frame bits.
//   show-char   : accept, then the frame bits.
//   number above 9999 or position beyond the display: dropped at accept.
//   The divider multiplies by a reciprocal and a single frame shifter serves
//   every frame; one request is in flight at a time, s_tready is low meanwhile.
// Reset returns the sequencer to idle and drops m_tvalid. A stall on the
// master side simply holds the current bit; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_serial_driver_unit
    import sssd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // number[13:0], character[21:14], position[23:22]
    input  wire logic        s_tuser,   // cmd
    // serial bit channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // data_bit[0], zero fill [7:1]
    output logic             m_tuser,   // frame_end
    output logic             m_tlast    // last
);

    // request fields
    logic [NUMBER_W-1:0]   in_number;
    logic [CHAR_W-1:0]     in_character;
    logic [POSITION_W-1:0] in_position;
    logic                  in_cmd;

    assign in_number    = s_tdata[13:0];
    assign in_character = s_tdata[21:14];
    assign in_position  = s_tdata[23:22];
    assign in_cmd       = s_tuser;

    state_t                 state_reg, state_next;
    logic [FRAME_BITS-1:0]  frame_reg, frame_next;      // shifts out MSB first
    logic [BIT_CNT_W-1:0]   bit_reg, bit_next;
    logic [POS_W-1:0]       pos_reg, pos_next;          // divide step / frame position
    logic                   single_reg, single_next;    // one-frame request
    logic [NUMBER_W-1:0]    val_reg, val_next;          // running quotient
    logic [DIGIT_W-1:0]     dig_reg [NUM_DIGITS];       // decimal digits, slot 0 leftmost
    logic [DIGIT_W-1:0]     dig_next [NUM_DIGITS];

    // shared divide-by-10 unit
    logic [PROD_W-1:0]      prod;
    logic [QUOT_W-1:0]      quot;
    logic [NUMBER_W-1:0]    quot_x10;
    logic [NUMBER_W-1:0]    rem_full;
    logic [DIGIT_W-1:0]     rem;

    logic s_req;
    logic m_req;
    logic bit_is_end;
    logic frame_is_last;
    logic pos_in_range;

    assign prod     = PROD_W'(val_reg) * PROD_W'(RECIP_10);
    assign quot     = prod[PROD_W-1:RECIP_SHIFT];
    assign quot_x10 = (NUMBER_W'(quot) << 3) + (NUMBER_W'(quot) << 1);
    assign rem_full = val_reg - quot_x10;
    assign rem      = rem_full[DIGIT_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SHIFT);
    assign s_req    = s_tvalid && s_tready;
    assign m_req    = m_tvalid && m_tready;

    assign bit_is_end    = (bit_reg == BIT_CNT_W'(FRAME_BITS - 1));
    assign frame_is_last = single_reg || (pos_reg == POS_W'(NUM_DIGITS - 1));
    assign pos_in_range  = (32'(in_position) < NUM_DIGITS);

    assign m_tdata = {7'd0, frame_reg[FRAME_BITS-1]};
    assign m_tuser = bit_is_end;
    assign m_tlast = bit_is_end && frame_is_last;

    always_comb
    begin
        state_next  = state_reg;
        frame_next  = frame_reg;
        bit_next    = bit_reg;
        pos_next    = pos_reg;
        single_next = single_reg;
        val_next    = val_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            dig_next[i] = dig_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_req)
                begin
                    pos_next = '0;
                    bit_next = '0;
                    val_next = in_number;
                    if (!in_cmd)
                    begin
                        single_next = 1'b0;
                        if (in_number <= NUMBER_LIMIT)
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    else if (pos_in_range)
                    begin
                        single_next = 1'b1;
                        frame_next  = {char_glyph(in_character),
                                       select_byte(3'(in_position))};
                        state_next  = ST_SHIFT;
                    end
                end
            end

            ST_DIV:
            begin
                // rightmost digit first; new digit enters slot 0
                val_next = NUMBER_W'(quot);
                for (int i = NUM_DIGITS - 1; i > 0; i--)
                begin
                    dig_next[i] = dig_reg[i-1];
                end
                dig_next[0] = rem;
                if (pos_reg == POS_W'(NUM_DIGITS - 1))
                begin
                    pos_next   = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end

            ST_LOAD:
            begin
                frame_next = {digit_glyph(dig_reg[0]), select_byte(3'(pos_reg))};
                for (int i = 0; i < NUM_DIGITS - 1; i++)
                begin
                    dig_next[i] = dig_reg[i+1];
                end
                bit_next   = '0;
                state_next = ST_SHIFT;
            end

            ST_SHIFT:
            begin
                if (m_req)
                begin
                    frame_next = frame_reg << 1;
                    bit_next   = bit_reg + 1'b1;
                    if (bit_is_end)
                    begin
                        if (frame_is_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            pos_next   = pos_reg + 1'b1;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            bit_reg    <= '0;
            pos_reg    <= '0;
            single_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bit_reg    <= bit_next;
            pos_reg    <= pos_next;
            single_reg <= single_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        val_reg   <= val_next;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            dig_reg[i] <= dig_next[i];
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // never taking a request while bits are still going out
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request accepted while shifting");

    // the final bit of a request always closes a frame
    a_last_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("last bit not at frame end");

    // after the final bit the block is free again
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("not idle after final bit");

    // frame end is followed by a load or by idle, never by another bit at once
    a_gap_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tuser) |=> !m_tvalid)
        else $error("no load gap between frames");

endmodule

`default_nettype wire

[tb/seven_segment_serial_driver_unit_tb.sv]
// ----------------------------------------------------------------------------
// seven_segment_serial_driver_unit_tb
// Self-checking bench for the serial seven-segment driver: show-number and
// show-character requests go in, every shifted bit is predicted and compared
// against m_tdata/m_tuser/m_tlast under four input/output pacing mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_serial_driver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sssd_pkg::*;

    localparam bit CMD_SHOW_NUMBER = 1'b0;
    localparam bit CMD_SHOW_CHAR   = 1'b1;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 100;    // a bit over the length of one number request
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PER_MIX  = 52;

    // active-low segment patterns
    localparam bit [7:0] DIGIT_SEGMENTS [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };
    localparam bit [7:0] LETTER_SEGMENTS [26] = '{
        8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hC2, 8'h89, 8'hCF,
        8'hE1, 8'h8A, 8'hC7, 8'hEA, 8'hC8, 8'hC0, 8'h8C, 8'h4A, 8'hCC,
        8'h92, 8'h87, 8'hC1, 8'hC1, 8'hD5, 8'h89, 8'h91, 8'hA4
    };
    localparam bit [7:0] BLANK_SEGMENTS = 8'hFF;

    typedef struct packed {
        bit data_bit;
        bit frame_end;
        bit last;
    } serial_bit_t;

    // Predicts the shifted bit stream per request and checks it in order.
    class segment_frame_board;
        serial_bit_t pending_bits [$];
        int          mismatches;
        int          bits_checked;
        int          number_requests;
        int          char_requests;
        int          dropped_requests;

        // one frame: segment byte MSB first, then digit select MSB first
        function void push_frame(bit [7:0] segments, int unsigned pos);
            bit [15:0]   frame;
            serial_bit_t b;
            frame = {segments, (8'hFF << NUM_DIGITS) | (8'h01 << pos)};
            for (int i = 2 * BYTE_BITS - 1; i >= 0; i--)
            begin
                b.data_bit  = frame[i];
                b.frame_end = (i == 0);
                b.last      = 1'b0;
                pending_bits.push_back(b);
            end
        endfunction

        function void note_request(bit cmd, bit [13:0] number, bit [7:0] character,
                                   bit [1:0] position);
            int unsigned scale;
            bit [7:0]    folded;
            bit [7:0]    segments;
            if (cmd == CMD_SHOW_NUMBER)
            begin
                number_requests++;
                if (number > NUMBER_LIMIT)
                begin
                    dropped_requests++;
                    return;
                end
                scale = 1;
                for (int p = 1; p < NUM_DIGITS; p++)
                    scale *= 10;
                for (int p = 0; p < NUM_DIGITS; p++)
                begin
                    push_frame(DIGIT_SEGMENTS[(number / scale) % 10], p);
                    if (scale > 1)
                        scale /= 10;
                end
            end
            else
            begin
                char_requests++;
                if (position >= NUM_DIGITS)
                begin
                    dropped_requests++;
                    return;
                end
                folded = character;
                if (folded >= CHAR_LC_A && folded <= CHAR_LC_Z)
                    folded = folded - CASE_FOLD;
                if (folded >= CHAR_ZERO && folded <= CHAR_NINE)
                    segments = DIGIT_SEGMENTS[folded - CHAR_ZERO];
                else if (folded >= CHAR_UC_A && folded <= CHAR_UC_Z)
                    segments = LETTER_SEGMENTS[folded - CHAR_UC_A];
                else
                    segments = BLANK_SEGMENTS;
                push_frame(segments, position);
            end
            pending_bits[pending_bits.size() - 1].last = 1'b1;
        endfunction

        function void check_bit(bit [7:0] tdata, bit tuser, bit tlast);
            serial_bit_t want;
            if (pending_bits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected bit: tdata=%02h frame_end=%0b last=%0b",
                             $realtime, tdata, tuser, tlast);
                return;
            end
            want = pending_bits.pop_front();
            bits_checked++;
            if (tdata != {7'd0, want.data_bit} || tuser != want.frame_end
                || tlast != want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"[%0t] bit %0d: tdata exp %02h got %02h, ",
                              "frame_end exp %0b got %0b, last exp %0b got %0b"},
                             $realtime, bits_checked, {7'd0, want.data_bit}, tdata,
                             want.frame_end, tuser, want.last, tlast);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;     // number[13:0], character[21:14], position[23:22]
    logic        s_tuser   = 1'b0;   // cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;            // data_bit[0], zero fill [7:1]
    logic        m_tuser;            // frame_end
    logic        m_tlast;            // last

    segment_frame_board board = new();

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    bit          hold_off_armed     = 1'b0;
    int unsigned cycle_count        = 0;

    seven_segment_serial_driver_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a stuck handshake or a lost bit ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bits still expected",
                     cycle_count, board.pending_bits.size());
            $display("seven_segment_serial_driver_unit regression: fail");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off when armed so the
    // block stays busy and its request channel backs up.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_armed)
            begin
                hold_off_armed = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Sampled mid-cycle: all outputs and m_tready are settled for the next edge,
    // where the handshake then takes place.
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_bit(m_tdata, m_tuser, m_tlast);
    end

    // Offers one request, idles beforehand at the current rate and returns at
    // the edge where the block takes it. s_tvalid stays high into the next
    // request unless an idle cycle follows.
    task automatic send_request(bit cmd, bit [13:0] number, bit [7:0] character,
                                bit [1:0] position);
        bit ready_seen;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {position, character, number};
        do
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        board.note_request(cmd, number, character, position);
    endtask

    // Mostly in-range numbers and printable text, with some oversized numbers
    // and arbitrary byte codes; unused fields always carry junk.
    task automatic send_random_request();
        bit [13:0] number;
        bit [7:0]  character;
        bit [1:0]  position;
        int unsigned pick;
        number    = 14'($urandom_range(16383));
        character = 8'($urandom_range(255));
        position  = 2'($urandom_range(3));
        pick      = $urandom_range(99);
        if ($urandom_range(1) == 0)
        begin
            if (pick < 85)
                number = 14'($urandom_range(9999));
            send_request(CMD_SHOW_NUMBER, number, character, position);
        end
        else
        begin
            if (pick < 25)
                character = 8'(CHAR_UC_A + $urandom_range(25));
            else if (pick < 50)
                character = 8'(CHAR_LC_A + $urandom_range(25));
            else if (pick < 70)
                character = 8'(CHAR_ZERO + $urandom_range(9));
            send_request(CMD_SHOW_CHAR, number, character, position);
        end
    endtask

    task automatic wait_for_drain();
        while (board.pending_bits.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: number extremes and digit coverage, out-of-range drops
        send_request(CMD_SHOW_NUMBER, 14'd0,     8'hFF, 2'd3);
        send_request(CMD_SHOW_NUMBER, 14'd9999,  8'h00, 2'd0);
        send_request(CMD_SHOW_NUMBER, 14'd1234,  8'h41, 2'd1);
        send_request(CMD_SHOW_NUMBER, 14'd5678,  8'h5A, 2'd2);
        send_request(CMD_SHOW_NUMBER, 14'd907,   8'h20, 2'd0);
        send_request(CMD_SHOW_NUMBER, 14'd10000, 8'h30, 2'd1);
        send_request(CMD_SHOW_NUMBER, 14'd16383, 8'h39, 2'd2);
        // characters: case folding, digits, letters, blanks and table edges
        send_request(CMD_SHOW_CHAR, 14'd16383, 8'h61, 2'd0);  // a
        send_request(CMD_SHOW_CHAR, 14'd0,     8'h7A, 2'd1);  // z
        send_request(CMD_SHOW_CHAR, 14'd9999,  8'h41, 2'd2);  // A
        send_request(CMD_SHOW_CHAR, 14'd10000, 8'h5A, 2'd3);  // Z
        send_request(CMD_SHOW_CHAR, 14'd5,     8'h71, 2'd0);  // q, segment bit 7 low
        send_request(CMD_SHOW_CHAR, 14'd77,    8'h30, 2'd1);  // 0
        send_request(CMD_SHOW_CHAR, 14'd123,   8'h39, 2'd2);  // 9
        send_request(CMD_SHOW_CHAR, 14'd4095,  8'h20, 2'd3);  // space
        send_request(CMD_SHOW_CHAR, 14'd8191,  8'h00, 2'd0);
        send_request(CMD_SHOW_CHAR, 14'd2,     8'hFF, 2'd1);
        send_request(CMD_SHOW_CHAR, 14'd3,     8'h80, 2'd2);
        send_request(CMD_SHOW_CHAR, 14'd4,     8'h40, 2'd3);  // @, just below A
        send_request(CMD_SHOW_CHAR, 14'd6,     8'h5B, 2'd0);  // [, just above Z
        send_request(CMD_SHOW_CHAR, 14'd7,     8'h60, 2'd1);  // `, just below a
        send_request(CMD_SHOW_CHAR, 14'd8,     8'h7B, 2'd2);  // {, just above z
        send_request(CMD_SHOW_CHAR, 14'd9,     8'h2F, 2'd3);  // /, just below 0
        send_request(CMD_SHOW_CHAR, 14'd10,    8'h3A, 2'd0);  // :, just above 9

        // pacing mixes: none, input idle, output stall, both lightly
        for (int mix = 0; mix < 4; mix++)
        begin
            wait_for_drain();
            case (mix)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
                default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
            endcase
            // long output hold-off while requests keep coming back to back
            if (mix == 2)
                hold_off_armed = 1'b1;
            repeat (RANDOM_PER_MIX) send_random_request();
        end

        @(posedge clk);
        s_tvalid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d number and %0d character requests (%0d dropped), %0d bits",
                 board.number_requests, board.char_requests, board.dropped_requests,
                 board.bits_checked);
        $display("pacing: free-running, idle input, stalled output, light mix; %0d-cycle hold-off",
                 HOLD_OFF_CYCLES);
        if (board.mismatches == 0 && board.pending_bits.size() == 0)
        begin
            $display("seven_segment_serial_driver_unit regression: pass");
        end
        else
        begin
            $display("%0d mismatches, %0d bits never seen",
                     board.mismatches, board.pending_bits.size());
            $display("seven_segment_serial_driver_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/sssd_pkg.sv
rtl/seven_segment_serial_driver_unit.sv
tb/seven_segment_serial_driver_unit_tb.sv
